// ===== hdl/vrrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring log package
// Types, constants and small helpers shared by the record ring log modules.
// ----------------------------------------------------------------------------
package vrrl_pkg;

    localparam int STORE_BYTES_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int FOUND_W         = $clog2(MAX_RESULTS + 1);

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    // A head tag of zero marks a byte where no record starts.
    localparam logic [2:0] TAG_NONE     = 3'd0;
    localparam logic [2:0] TAG_MAX_LIVE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_GATHER_RD,
        ST_GATHER_CAP,
        ST_STORE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] tag;
    } t_rd_data;

    // Record length in bytes minus one.
    function automatic logic [2:0] len_m1(input logic [1:0] code);
        logic [2:0] res;
        case (code)
            2'd0:    res = 3'd0;
            2'd1:    res = 3'd1;
            2'd2:    res = 3'd3;
            default: res = 3'd7;
        endcase
        return res;
    endfunction

    // Record length in bytes.
    function automatic logic [3:0] rec_len(input logic [1:0] code);
        return {1'b0, len_m1(code)} + 4'd1;
    endfunction

endpackage

// ===== hdl/vrrl_pos_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring position adder
// Adds an offset to a store position and folds the sum back into the ring.
// ----------------------------------------------------------------------------
module vrrl_pos_unit #(
    parameter int STORE_BYTES = vrrl_pkg::STORE_BYTES_DEF,
    parameter int AW          = $clog2(STORE_BYTES)
) (
    input  logic [AW-1:0] i_base,
    input  logic [AW:0]   i_off,
    output logic [AW-1:0] o_pos
);

    localparam logic [AW:0] DEPTH = (AW + 1)'(STORE_BYTES);

    logic [AW:0] w_sum;
    logic [AW:0] w_fold;

    // The sum stays below twice the depth, so one subtract folds it.
    always_comb begin
        w_sum  = {1'b0, i_base} + i_off;
        w_fold = (w_sum >= DEPTH) ? (w_sum - DEPTH) : w_sum;
        o_pos  = w_fold[AW-1:0];
    end

endmodule

// ===== hdl/vrrl_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte and tag store
// Single write, single registered read memory of bytes with head tags.
// ----------------------------------------------------------------------------
module vrrl_store #(
    parameter int STORE_BYTES = vrrl_pkg::STORE_BYTES_DEF,
    parameter int AW          = $clog2(STORE_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [7:0]         i_wr_byte,
    input  logic [2:0]         i_wr_tag,
    input  logic [AW-1:0]      i_rd_addr,
    output vrrl_pkg::t_rd_data o_rd
);

    logic [7:0]             r_byte_mem [STORE_BYTES];
    logic [2:0]             r_tag_mem  [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_vld;
    vrrl_pkg::t_rd_data     r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_byte_mem[i_wr_addr] <= i_wr_byte;
            r_tag_mem[i_wr_addr]  <= i_wr_tag;
        end
        r_rd.data <= r_byte_mem[i_rd_addr];
        r_rd.tag  <= r_vld[i_rd_addr] ? r_tag_mem[i_rd_addr] : vrrl_pkg::TAG_NONE;
    end

    // Tags read as empty until their entry has been written once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== hdl/variable_record_ring_log.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable length record ring log
// Circular byte log of 1, 2, 4 and 8 byte records with append and dump.
// ----------------------------------------------------------------------------
// The block holds STORE_BYTES bytes in a ring with a head tag per byte. An
// append item (command 0) writes its record little-endian one byte per cycle,
// wrapping at the end of the store, overwriting and untagging the oldest bytes;
// it produces no result. A dump item (command 1) walks the ring from the oldest
// byte up to the write position and emits every intact record in age order, at
// most sixteen, with is_last on the final one; an empty log yields a single
// result with no_record and is_last set. The walk reads the store one address
// at a time, stepping over untagged bytes one by one and gathering each record
// byte by byte, and it waits while the output register is stalled. One position
// adder that folds sums back into the ring serves all address generation. The
// input side is ready only while no item is in progress; results leave through
// an output register, so a finished dump can be followed by the next item while
// its last result still waits. The tag store is cleared at reset; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module variable_record_ring_log #(
    parameter int STORE_BYTES = vrrl_pkg::STORE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [1:0]  i_size_code,
    input  logic [63:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_record_value,
    output logic [1:0]  o_record_size_code,
    output logic        o_no_record,
    output logic        o_is_last
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int FW = vrrl_pkg::FOUND_W;
    localparam logic [AW:0]   DEPTH    = (AW + 1)'(STORE_BYTES);
    localparam logic [AW-1:0] LAST_POS = AW'(STORE_BYTES - 1);
    localparam logic [FW-1:0] MAX_REC  = FW'(vrrl_pkg::MAX_RESULTS);

    vrrl_pkg::t_state r_state, n_state;

    // Append and walk registers.
    logic [1:0]    r_code,    n_code;
    logic [63:0]   r_value,   n_value;
    logic [2:0]    r_k,       n_k;
    logic [AW-1:0] r_wp,      n_wp;
    logic          r_wrapped, n_wrapped;
    logic [AW-1:0] r_start,   n_start;
    logic [AW:0]   r_span,    n_span;
    logic [AW:0]   r_d,       n_d;
    logic [AW-1:0] r_pos,     n_pos;
    logic [FW-1:0] r_found,   n_found;

    // Record being gathered and the one found before it.
    logic [63:0]   r_cur_val,   n_cur_val;
    logic [1:0]    r_cur_code,  n_cur_code;
    logic [63:0]   r_pend_val,  n_pend_val;
    logic [1:0]    r_pend_code, n_pend_code;
    logic          r_have_pend, n_have_pend;

    // Output register.
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_value, n_out_value;
    logic [1:0]    r_out_code,  n_out_code;
    logic          r_out_none,  n_out_none;
    logic          r_out_last,  n_out_last;

    // Shared position adder and store ports.
    logic [AW-1:0]      w_base;
    logic [AW:0]        w_off;
    logic [AW-1:0]      w_pos;
    logic               w_wr_en;
    logic [7:0]         w_wr_byte;
    logic [2:0]         w_wr_tag;
    vrrl_pkg::t_rd_data w_rd;

    logic          w_accept;
    logic          w_out_free;
    logic [1:0]    w_tag_code;
    logic [AW:0]   w_rec_end;

    vrrl_pos_unit #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_pos (
        .i_base (w_base),
        .i_off  (w_off),
        .o_pos  (w_pos)
    );

    // Appends write at the write position; every read goes through the adder.
    vrrl_store #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_byte (w_wr_byte),
        .i_wr_tag  (w_wr_tag),
        .i_rd_addr (w_pos),
        .o_rd      (w_rd)
    );

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_tag_code = 2'(w_rd.tag - 3'd1);
    assign w_rec_end  = r_d + (AW + 1)'(vrrl_pkg::rec_len(w_tag_code));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrrl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_value     = r_value;
        n_k         = r_k;
        n_wp        = r_wp;
        n_wrapped   = r_wrapped;
        n_start     = r_start;
        n_span      = r_span;
        n_d         = r_d;
        n_pos       = r_pos;
        n_found     = r_found;
        n_cur_val   = r_cur_val;
        n_cur_code  = r_cur_code;
        n_pend_val  = r_pend_val;
        n_pend_code = r_pend_code;
        n_have_pend = r_have_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_code  = r_out_code;
        n_out_none  = r_out_none;
        n_out_last  = r_out_last;

        w_base    = r_wp;
        w_off     = '0;
        w_wr_en   = 1'b0;
        w_wr_byte = r_value[7:0];
        w_wr_tag  = (r_k == 3'd0) ? ({1'b0, r_code} + 3'd1) : vrrl_pkg::TAG_NONE;

        case (r_state)
            vrrl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_command == vrrl_pkg::CMD_APPEND) begin
                        n_code  = i_size_code;
                        n_value = i_value;
                        n_k     = 3'd0;
                        n_state = vrrl_pkg::ST_APPEND;
                    end else begin
                        // Once wrapped, the oldest byte sits at the write position.
                        n_start     = r_wrapped ? r_wp : '0;
                        n_span      = r_wrapped ? DEPTH : {1'b0, r_wp};
                        n_d         = '0;
                        n_found     = '0;
                        n_have_pend = 1'b0;
                        n_state     = vrrl_pkg::ST_WALK_RD;
                    end
                end
            end
            vrrl_pkg::ST_APPEND: begin
                w_off   = (AW + 1)'(1);
                w_wr_en = 1'b1;
                n_wp    = w_pos;
                n_value = {8'h00, r_value[63:8]};
                n_k     = r_k + 3'd1;
                if (r_wp == LAST_POS) begin
                    n_wrapped = 1'b1;
                end
                if (r_k == vrrl_pkg::len_m1(r_code)) begin
                    n_state = vrrl_pkg::ST_IDLE;
                end
            end
            vrrl_pkg::ST_WALK_RD: begin
                w_base = r_start;
                w_off  = r_d;
                if (r_d >= r_span) begin
                    n_state = vrrl_pkg::ST_FINISH;
                end else begin
                    n_pos   = w_pos;
                    n_state = vrrl_pkg::ST_WALK_CHK;
                end
            end
            vrrl_pkg::ST_WALK_CHK: begin
                if (w_rd.tag == vrrl_pkg::TAG_NONE || w_rd.tag > vrrl_pkg::TAG_MAX_LIVE) begin
                    // Leftover byte of an overwritten record.
                    n_d     = r_d + (AW + 1)'(1);
                    n_state = vrrl_pkg::ST_WALK_RD;
                end else if (w_rec_end > r_span) begin
                    n_state = vrrl_pkg::ST_FINISH;
                end else begin
                    n_cur_code = w_tag_code;
                    n_cur_val  = {56'd0, w_rd.data};
                    n_k        = 3'd1;
                    n_state    = (w_tag_code == 2'd0) ? vrrl_pkg::ST_STORE
                                                      : vrrl_pkg::ST_GATHER_RD;
                end
            end
            vrrl_pkg::ST_GATHER_RD: begin
                w_base  = r_pos;
                w_off   = (AW + 1)'(r_k);
                n_state = vrrl_pkg::ST_GATHER_CAP;
            end
            vrrl_pkg::ST_GATHER_CAP: begin
                n_cur_val[{r_k, 3'b000} +: 8] = w_rd.data;
                n_k = r_k + 3'd1;
                n_state = (r_k == vrrl_pkg::len_m1(r_cur_code)) ? vrrl_pkg::ST_STORE
                                                                 : vrrl_pkg::ST_GATHER_RD;
            end
            vrrl_pkg::ST_STORE: begin
                // The previous record is known not to be last once another exists.
                if (!r_have_pend || w_out_free) begin
                    if (r_have_pend) begin
                        n_out_valid = 1'b1;
                        n_out_value = r_pend_val;
                        n_out_code  = r_pend_code;
                        n_out_none  = 1'b0;
                        n_out_last  = 1'b0;
                    end
                    n_pend_val  = r_cur_val;
                    n_pend_code = r_cur_code;
                    n_have_pend = 1'b1;
                    n_found     = r_found + FW'(1);
                    n_d         = r_d + (AW + 1)'(vrrl_pkg::rec_len(r_cur_code));
                    n_state     = (n_found == MAX_REC) ? vrrl_pkg::ST_FINISH
                                                       : vrrl_pkg::ST_WALK_RD;
                end
            end
            vrrl_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_none  = !r_have_pend;
                    n_out_value = r_have_pend ? r_pend_val : 64'd0;
                    n_out_code  = r_have_pend ? r_pend_code : 2'd0;
                    n_state     = vrrl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vrrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_wrapped   <= n_wrapped;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_value     <= n_value;
        r_k         <= n_k;
        r_start     <= n_start;
        r_span      <= n_span;
        r_d         <= n_d;
        r_pos       <= n_pos;
        r_found     <= n_found;
        r_cur_val   <= n_cur_val;
        r_cur_code  <= n_cur_code;
        r_pend_val  <= n_pend_val;
        r_pend_code <= n_pend_code;
        r_out_value <= n_out_value;
        r_out_code  <= n_out_code;
        r_out_none  <= n_out_none;
        r_out_last  <= n_out_last;
    end

    assign o_in_ready         = (r_state == vrrl_pkg::ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_record_value     = r_out_value;
    assign o_record_size_code = r_out_code;
    assign o_no_record        = r_out_none;
    assign o_is_last          = r_out_last;

endmodule

// ===== hdl/vrrl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring log checker
// Port-level assertions for the record ring log, bound to the top level.
// ----------------------------------------------------------------------------
module vrrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_record_value,
    input logic [1:0]  o_record_size_code,
    input logic        o_no_record,
    input logic        o_is_last
);

    // A stalled result holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_record_value) && $stable(o_record_size_code)
            && $stable(o_no_record) && $stable(o_is_last))
        else $error("result changed while stalled");

    // An empty dump is a single final result with zero fields.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_record |->
            o_is_last && o_record_value == 64'd0 && o_record_size_code == 2'd0)
        else $error("empty dump result malformed");

    // Record bits above the record length are zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            !((o_record_size_code == 2'd0 && o_record_value[63:8] != 56'd0)
            || (o_record_size_code == 2'd1 && o_record_value[63:16] != 48'd0)
            || (o_record_size_code == 2'd2 && o_record_value[63:32] != 32'd0)))
        else $error("record value wider than its size");

    // Every item occupies the block, so input ready drops once it is accepted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted in back-to-back cycles");

    // A valid result never carries unknown bits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            !$isunknown({o_record_value, o_record_size_code, o_no_record, o_is_last}))
        else $error("result carries unknown bits");

endmodule

bind variable_record_ring_log vrrl_checker u_vrrl_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_record_value     (o_record_value),
    .o_record_size_code (o_record_size_code),
    .o_no_record        (o_no_record),
    .o_is_last          (o_is_last)
);

// ===== tb/sv/variable_record_ring_log_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring log testbench
// Drives append and dump items into the record ring log, predicts each dump
// from a shadow copy or a pinned row, and checks each result field by field.
// ----------------------------------------------------------------------------
// A short directed table comes first: a dump of the empty log, a full-width
// record of all ones, one record of every size, a wrap that leaves the remains
// of a broken record behind, and a run of sixteen one-byte records that fills
// the ring. Two of those dumps carry a fixed expectation; the rest use the
// shadow model. Random appends and dumps follow. Both handshakes idle at
// random, except during one calm stretch in the middle of the random part.
// ----------------------------------------------------------------------------
module variable_record_ring_log_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int RING_BYTES     = vrrl_pkg::STORE_BYTES_DEF;
    localparam int RANDOM_ITEMS   = 175;
    localparam int IDLE_PERCENT   = 9;
    // The limit is far longer than a full dump with its results takes.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PRINT_CAP      = 40;

    typedef enum logic [1:0] {
        SZ_BYTE   = 2'd0,
        SZ_HALF   = 2'd1,
        SZ_WORD   = 2'd2,
        SZ_DOUBLE = 2'd3
    } t_size;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  size_code;
        logic        no_record;
        logic        is_last;
    } t_log_record;

    // One stimulus item; a pinned row carries its own single expected result.
    typedef struct packed {
        logic        command;
        logic [1:0]  size_code;
        logic [63:0] value;
        logic        pinned;
        t_log_record pinned_rec;
    } t_log_item;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_command   = vrrl_pkg::CMD_APPEND;
    logic [1:0]  i_size_code = SZ_BYTE;
    logic [63:0] i_value     = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_record_value;
    logic [1:0]  o_record_size_code;
    logic        o_no_record;
    logic        o_is_last;

    // Shadow copy of the ring, advanced as each item is accepted.
    logic [7:0]  ring_bytes [RING_BYTES];
    logic [2:0]  ring_tags  [RING_BYTES];
    int unsigned ring_wpos;
    bit          ring_wrapped;

    t_log_record pending_records[$];
    t_log_item   directed_rows[$];

    int  error_count     = 0;
    int  appends_sent    = 0;
    int  dumps_sent      = 0;
    int  records_checked = 0;
    int  quiet_cycles    = 0;
    bit  calm            = 1'b0;

    variable_record_ring_log u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_size_code        (i_size_code),
        .i_value            (i_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_record_value     (o_record_value),
        .o_record_size_code (o_record_size_code),
        .o_no_record        (o_no_record),
        .o_is_last          (o_is_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // An append writes its low bytes little-endian from the write position,
    // untags every byte it covers and tags only its own first byte.
    function automatic void apply_append(input logic [1:0] code, input logic [63:0] value);
        int unsigned nbytes;
        int unsigned pos;
        nbytes = 1 << code;
        for (int k = 0; k < nbytes; k++) begin
            pos = (ring_wpos + k) % RING_BYTES;
            ring_bytes[pos] = value[8 * k +: 8];
            ring_tags[pos]  = vrrl_pkg::TAG_NONE;
        end
        ring_tags[ring_wpos] = {1'b0, code} + 3'd1;
        if (ring_wpos + nbytes >= RING_BYTES) begin
            ring_wrapped = 1'b1;
        end
        ring_wpos = (ring_wpos + nbytes) % RING_BYTES;
    endfunction

    // A dump walks from the oldest byte to the write position. Untagged bytes
    // are remains of overwritten records and are stepped over one at a time.
    function automatic void predict_dump();
        int unsigned start;
        int unsigned span;
        int unsigned d;
        int unsigned p;
        int unsigned nbytes;
        int          found;
        logic [2:0]  tag;
        t_log_record rec;
        start = ring_wrapped ? ring_wpos : 0;
        span  = ring_wrapped ? RING_BYTES : ring_wpos;
        d     = 0;
        found = 0;
        while (d < span && found < vrrl_pkg::MAX_RESULTS) begin
            p   = (start + d) % RING_BYTES;
            tag = ring_tags[p];
            if (tag == vrrl_pkg::TAG_NONE || tag > vrrl_pkg::TAG_MAX_LIVE) begin
                d++;
                continue;
            end
            nbytes = 1 << (tag - 3'd1);
            if (d + nbytes > span) begin
                break;
            end
            rec = '0;
            for (int k = 0; k < nbytes; k++) begin
                rec.value[8 * k +: 8] = ring_bytes[(p + k) % RING_BYTES];
            end
            rec.size_code = 2'(tag - 3'd1);
            pending_records.push_back(rec);
            found++;
            d += nbytes;
        end
        if (found == 0) begin
            rec           = '0;
            rec.no_record = 1'b1;
            rec.is_last   = 1'b1;
            pending_records.push_back(rec);
        end else begin
            rec         = pending_records.pop_back();
            rec.is_last = 1'b1;
            pending_records.push_back(rec);
        end
    endfunction

    function automatic void add_row(input logic cmd, input logic [1:0] code,
                                    input logic [63:0] value, input logic pinned,
                                    input t_log_record rec);
        t_log_item row;
        row.command    = cmd;
        row.size_code  = code;
        row.value      = value;
        row.pinned     = pinned;
        row.pinned_rec = rec;
        directed_rows.push_back(row);
    endfunction

    // Presents one item and returns in the step of the edge that accepts it.
    // Valid is lowered only when a gap is drawn, so it is never dropped and
    // raised within the same step.
    task automatic send_item(input t_log_item item);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= item.command;
        i_size_code <= item.size_code;
        i_value     <= item.value;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (item.command == vrrl_pkg::CMD_APPEND) begin
            apply_append(item.size_code, item.value);
            appends_sent++;
        end else begin
            dumps_sent++;
            if (item.pinned) begin
                pending_records.push_back(item.pinned_rec);
            end else begin
                predict_dump();
            end
        end
    endtask

    // Result side: check on each accepted result, then draw the next ready.
    always @(posedge i_clk) begin
        t_log_record want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_records.size() == 0) begin
                report_error($sformatf("result with nothing expected: value %h size %0d",
                                       o_record_value, o_record_size_code));
            end else begin
                want = pending_records.pop_front();
                if (o_record_value !== want.value) begin
                    report_error($sformatf("record_value got %h want %h",
                                           o_record_value, want.value));
                end
                if (o_record_size_code !== want.size_code) begin
                    report_error($sformatf("record_size_code got %0d want %0d",
                                           o_record_size_code, want.size_code));
                end
                if (o_no_record !== want.no_record) begin
                    report_error($sformatf("no_record got %b want %b",
                                           o_no_record, want.no_record));
                end
                if (o_is_last !== want.is_last) begin
                    report_error($sformatf("is_last got %b want %b",
                                           o_is_last, want.is_last));
                end
            end
            records_checked++;
        end
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_records.size());
                $display("status: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_log_item   item;
        t_log_record rec;

        for (int i = 0; i < RING_BYTES; i++) begin
            ring_bytes[i] = '0;
            ring_tags[i]  = vrrl_pkg::TAG_NONE;
        end
        ring_wpos    = 0;
        ring_wrapped = 1'b0;

        // Directed rows. The empty dump and the lone all-ones record are
        // typed in; everything else is left to the shadow model.
        rec = '0;
        rec.no_record = 1'b1;
        rec.is_last   = 1'b1;
        add_row(vrrl_pkg::CMD_DUMP, SZ_DOUBLE, '1, 1'b1, rec);
        add_row(vrrl_pkg::CMD_APPEND, SZ_DOUBLE, '1, 1'b0, '0);
        rec = '0;
        rec.value     = '1;
        rec.size_code = SZ_DOUBLE;
        rec.is_last   = 1'b1;
        add_row(vrrl_pkg::CMD_DUMP, SZ_BYTE, '0, 1'b1, rec);
        // Upper bits beyond each length must be dropped.
        add_row(vrrl_pkg::CMD_APPEND, SZ_BYTE, 64'hFFFF_FFFF_FFFF_FF5A, 1'b0, '0);
        add_row(vrrl_pkg::CMD_APPEND, SZ_HALF, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
        add_row(vrrl_pkg::CMD_APPEND, SZ_WORD, 64'h8000_0000_DEAD_BEEF, 1'b0, '0);
        add_row(vrrl_pkg::CMD_DUMP, SZ_BYTE, '0, 1'b0, '0);
        // This one wraps and cuts into the eight-byte record at the front.
        add_row(vrrl_pkg::CMD_APPEND, SZ_HALF, 64'h0000_0000_0000_A55A, 1'b0, '0);
        add_row(vrrl_pkg::CMD_DUMP, SZ_HALF, '0, 1'b0, '0);
        // Sixteen one-byte records fill the ring: the most a dump can return.
        for (int k = 0; k < RING_BYTES; k++) begin
            add_row(vrrl_pkg::CMD_APPEND, SZ_BYTE,
                    {$urandom(), 24'($urandom_range(16777215)), 8'(k * 17)},
                    1'b0, '0);
        end
        add_row(vrrl_pkg::CMD_DUMP, SZ_WORD, '0, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i]);
        end

        // Random part: mostly appends of every size, with a dump about one
        // item in five. The middle stretch runs with no idling at all.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 60 && i < 115);
            item           = '0;
            item.command   = ($urandom_range(4) == 0) ? vrrl_pkg::CMD_DUMP
                                                      : vrrl_pkg::CMD_APPEND;
            item.size_code = 2'($urandom_range(3));
            item.value     = {$urandom(), $urandom()};
            send_item(item);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_records.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d appends and %0d dumps, %0d records checked",
                 appends_sent, dumps_sent, records_checked);
        $display("%0d mismatches, %0d results still expected",
                 error_count, pending_records.size());
        if (error_count == 0 && pending_records.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== variable_record_ring_log.f =====
hdl/vrrl_pkg.sv
hdl/vrrl_pos_unit.sv
hdl/vrrl_store.sv
hdl/variable_record_ring_log.sv
hdl/vrrl_checker.sv
tb/sv/variable_record_ring_log_tb.sv
